[rtl/multi_channel_threshold_alarm_core_macros.svh]
// Assertion macros shared by the threshold alarm checker.
`ifndef MULTI_CHANNEL_THRESHOLD_ALARM_CORE_MACROS_SVH
`define MULTI_CHANNEL_THRESHOLD_ALARM_CORE_MACROS_SVH

// Concurrent assertion that is switched off while reset is held.
`define MCTA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("threshold alarm assertion failed");

// Concurrent assertion that also checks behavior across reset.
`define MCTA_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("threshold alarm reset assertion failed");

`endif

[rtl/mcta_pkg.sv]
// Package with widths, codes and reset values of the threshold alarm core.
package mcta_pkg;

  localparam int SYS_W      = 3;
  localparam int CMD_W      = 2;
  localparam int VAL_W      = 16;
  localparam int TIME_W     = 32;
  localparam int CNT_W      = 8;
  localparam int TOT_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int NUM_SYSTEMS_DEF = 8;

  localparam logic [VAL_W-1:0] WARN_LEVEL_RST = VAL_W'(75);
  localparam logic [VAL_W-1:0] CRIT_LEVEL_RST = VAL_W'(90);
  localparam logic [VAL_W-1:0] REC_LEVEL_RST  = VAL_W'(60);
  localparam logic [CNT_W-1:0] MAX_CONSEC_RST = CNT_W'(3);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_WARN_LEVEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CRIT_LEVEL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REC_LEVEL  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CONSEC = 2'd3;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_WARN = 2'd1,
    ST_CRIT = 2'd2
  } status_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE      = 2'd0,
    CMD_ACK         = 2'd1,
    CMD_CLEAR_STATS = 2'd2,
    CMD_CLEAR_ESTOP = 2'd3
  } cmd_t;

endpackage

[rtl/multi_channel_threshold_alarm_core.sv]
// Top level of the multi-channel threshold alarm core with latched emergency stop.
//
// Usage: every input word is a command for one subsystem (sample, acknowledge
// warning, reset statistics or clear emergency stop). Both channels use a
// valid/ready handshake. Each accepted word yields exactly one result word with
// the subsystem's new status, the worst status over all subsystems, the
// emergency stop latch and the subsystem's statistics after the command.
// An accepted word is first held in the input register, then the grading,
// table update and result capture happen in one pass into the output
// register, which raises out_valid.
// Throughput is one word per cycle while the receiver keeps out_ready high;
// the per-subsystem tables are flip-flops that are read and written in that
// single pass, so a command sees every update made by the command before it.
// When the receiver stalls, the result word holds in the output register and
// one more command waits in the input register; in_ready drops only when both
// are full. The four configuration registers are written through the cfg port
// while the core is idle; the user must keep to this, the core does not check it.
// A synchronous active-low reset restores the default levels, clears all status
// and statistics, clears the stop latch and empties both pipeline registers.
module multi_channel_threshold_alarm_core #(
  parameter int NUM_SYSTEMS = mcta_pkg::NUM_SYSTEMS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Command channel.
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [mcta_pkg::CMD_W-1:0]       in_cmd,
  input  logic [mcta_pkg::SYS_W-1:0]       in_sys_index,
  input  logic [mcta_pkg::VAL_W-1:0]       in_sample_value,
  input  logic [mcta_pkg::TIME_W-1:0]      in_now_ms,
  // Result channel.
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [mcta_pkg::SYS_W-1:0]       out_sys,
  output logic [1:0]                       out_sys_status,
  output logic                             out_status_changed,
  output logic                             out_became_critical,
  output logic [1:0]                       out_overall_status,
  output logic                             out_estop_latched,
  output logic [mcta_pkg::CNT_W-1:0]       out_consec_count,
  output logic [mcta_pkg::TOT_W-1:0]       out_warn_total,
  output logic [mcta_pkg::TOT_W-1:0]       out_crit_total,
  output logic [mcta_pkg::TIME_W-1:0]      out_last_warn_ms,
  output logic [mcta_pkg::TIME_W-1:0]      out_last_crit_ms,
  // Configuration write port.
  input  logic                             cfg_we,
  input  logic [mcta_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mcta_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int IDX_W = (NUM_SYSTEMS > 1) ? $clog2(NUM_SYSTEMS) : 1;
  localparam int EXT_W = (IDX_W > mcta_pkg::SYS_W) ? IDX_W : mcta_pkg::SYS_W;
  // Wide enough to hold NUM_SYSTEMS itself for the range check.
  localparam int CMP_W = mcta_pkg::SYS_W + 2;

  // Configuration registers.
  logic [mcta_pkg::VAL_W-1:0] warn_lvl_r;
  logic [mcta_pkg::VAL_W-1:0] crit_lvl_r;
  logic [mcta_pkg::VAL_W-1:0] rec_lvl_r;
  logic [mcta_pkg::CNT_W-1:0] max_consec_r;

  // Input register.
  logic                          stg_valid_r;
  mcta_pkg::cmd_t                cmd_r;
  logic [mcta_pkg::SYS_W-1:0]    sys_r;
  logic [mcta_pkg::VAL_W-1:0]    val_r;
  logic [mcta_pkg::TIME_W-1:0]   now_r;

  // Per-subsystem state.
  mcta_pkg::status_t             status_r   [NUM_SYSTEMS];
  logic [mcta_pkg::CNT_W-1:0]    consec_r   [NUM_SYSTEMS];
  logic [mcta_pkg::TOT_W-1:0]    warn_tot_r [NUM_SYSTEMS];
  logic [mcta_pkg::TOT_W-1:0]    crit_tot_r [NUM_SYSTEMS];
  logic [mcta_pkg::TIME_W-1:0]   warn_ms_r  [NUM_SYSTEMS];
  logic [mcta_pkg::TIME_W-1:0]   crit_ms_r  [NUM_SYSTEMS];
  logic                          estop_r;
  logic                          estop_nxt;

  // Output register.
  logic                          out_valid_r;
  logic [mcta_pkg::SYS_W-1:0]    out_sys_r;
  mcta_pkg::status_t             out_status_r;
  logic                          out_changed_r;
  logic                          out_became_crit_r;
  mcta_pkg::status_t             out_overall_r;
  logic [mcta_pkg::CNT_W-1:0]    out_consec_r;
  logic [mcta_pkg::TOT_W-1:0]    out_warn_tot_r;
  logic [mcta_pkg::TOT_W-1:0]    out_crit_tot_r;
  logic [mcta_pkg::TIME_W-1:0]   out_warn_ms_r;
  logic [mcta_pkg::TIME_W-1:0]   out_crit_ms_r;

  // Processing signals.
  logic                          advance;
  logic                          sys_ok;
  logic [EXT_W-1:0]              sys_ext;
  logic [IDX_W-1:0]              idx;
  mcta_pkg::status_t             old_st;
  mcta_pkg::status_t             new_st;
  logic [mcta_pkg::CNT_W-1:0]    consec_cur;
  logic [mcta_pkg::TOT_W-1:0]    warn_tot_cur;
  logic [mcta_pkg::TOT_W-1:0]    crit_tot_cur;
  logic [mcta_pkg::CNT_W-1:0]    consec_upd;
  logic [mcta_pkg::TOT_W-1:0]    warn_tot_upd;
  logic [mcta_pkg::TOT_W-1:0]    crit_tot_upd;
  logic [mcta_pkg::TIME_W-1:0]   warn_ms_upd;
  logic [mcta_pkg::TIME_W-1:0]   crit_ms_upd;
  logic                          changed;
  logic                          any_crit;
  logic                          any_warn;
  mcta_pkg::status_t             worst;

  // The input register moves on whenever the output register is empty or
  // being emptied in this cycle, so both registers together sustain one word
  // per cycle while the receiver keeps out_ready high.
  assign advance  = stg_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !stg_valid_r || advance;

  // Indexes at or above NUM_SYSTEMS address no entry.
  assign sys_ok  = ({2'b00, sys_r} < CMP_W'(NUM_SYSTEMS));
  assign sys_ext = EXT_W'(sys_r);
  assign idx     = sys_ext[IDX_W-1:0];

  assign old_st       = status_r[idx];
  assign consec_cur   = consec_r[idx];
  assign warn_tot_cur = warn_tot_r[idx];
  assign crit_tot_cur = crit_tot_r[idx];

  // Grading of one command against the shared levels. The critical test
  // comes first, then the warning test, then the recovery test; anything in
  // between leaves the status alone, which gives the hysteresis band.
  always_comb begin
    new_st       = old_st;
    consec_upd   = consec_cur;
    warn_tot_upd = warn_tot_cur;
    crit_tot_upd = crit_tot_cur;
    warn_ms_upd  = warn_ms_r[idx];
    crit_ms_upd  = crit_ms_r[idx];
    case (cmd_r)
      mcta_pkg::CMD_SAMPLE: begin
        if (val_r >= crit_lvl_r) begin
          new_st       = mcta_pkg::ST_CRIT;
          crit_tot_upd = (crit_tot_cur != '1) ? crit_tot_cur + 1'b1 : crit_tot_cur;
          crit_ms_upd  = now_r;
        end else if (val_r >= warn_lvl_r) begin
          new_st       = mcta_pkg::ST_WARN;
          warn_tot_upd = (warn_tot_cur != '1) ? warn_tot_cur + 1'b1 : warn_tot_cur;
          warn_ms_upd  = now_r;
          consec_upd   = (consec_cur != '1) ? consec_cur + 1'b1 : consec_cur;
          // A run of warnings that reaches the limit escalates to critical.
          if (consec_upd >= max_consec_r) begin
            new_st       = mcta_pkg::ST_CRIT;
            crit_tot_upd = (crit_tot_cur != '1) ? crit_tot_cur + 1'b1 : crit_tot_cur;
            crit_ms_upd  = now_r;
          end
        end else if (val_r <= rec_lvl_r) begin
          if (old_st != mcta_pkg::ST_OK) begin
            new_st     = mcta_pkg::ST_OK;
            consec_upd = '0;
          end
        end
      end
      mcta_pkg::CMD_ACK: begin
        if (old_st == mcta_pkg::ST_WARN) begin
          new_st     = mcta_pkg::ST_OK;
          consec_upd = '0;
        end
      end
      mcta_pkg::CMD_CLEAR_STATS: begin
        consec_upd   = '0;
        warn_tot_upd = '0;
        crit_tot_upd = '0;
        warn_ms_upd  = '0;
        crit_ms_upd  = '0;
      end
      mcta_pkg::CMD_CLEAR_ESTOP: begin
        // Acts on the stop latch only, handled below.
      end
      default: begin
      end
    endcase
  end

  assign changed = sys_ok && (new_st != old_st);

  // Worst status over all subsystems as they stand after this command.
  always_comb begin
    any_crit = 1'b0;
    any_warn = 1'b0;
    for (int i = 0; i < NUM_SYSTEMS; i++) begin
      if (sys_ok && (idx == IDX_W'(i))) begin
        any_crit = any_crit | (new_st == mcta_pkg::ST_CRIT);
        any_warn = any_warn | (new_st == mcta_pkg::ST_WARN);
      end else begin
        any_crit = any_crit | (status_r[i] == mcta_pkg::ST_CRIT);
        any_warn = any_warn | (status_r[i] == mcta_pkg::ST_WARN);
      end
    end
    if (any_crit) begin
      worst = mcta_pkg::ST_CRIT;
    end else if (any_warn) begin
      worst = mcta_pkg::ST_WARN;
    end else begin
      worst = mcta_pkg::ST_OK;
    end
  end

  // Any move into critical sets the latch; the clear command drops it only
  // while no subsystem is critical, whatever subsystem it names.
  always_comb begin
    estop_nxt = estop_r;
    if (changed && (new_st == mcta_pkg::ST_CRIT)) begin
      estop_nxt = 1'b1;
    end
    if ((cmd_r == mcta_pkg::CMD_CLEAR_ESTOP) && (worst != mcta_pkg::ST_CRIT)) begin
      estop_nxt = 1'b0;
    end
  end

  // Control state, configuration and subsystem tables.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warn_lvl_r   <= mcta_pkg::WARN_LEVEL_RST;
      crit_lvl_r   <= mcta_pkg::CRIT_LEVEL_RST;
      rec_lvl_r    <= mcta_pkg::REC_LEVEL_RST;
      max_consec_r <= mcta_pkg::MAX_CONSEC_RST;
      stg_valid_r  <= 1'b0;
      out_valid_r  <= 1'b0;
      estop_r      <= 1'b0;
      for (int i = 0; i < NUM_SYSTEMS; i++) begin
        status_r[i]   <= mcta_pkg::ST_OK;
        consec_r[i]   <= '0;
        warn_tot_r[i] <= '0;
        crit_tot_r[i] <= '0;
        warn_ms_r[i]  <= '0;
        crit_ms_r[i]  <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mcta_pkg::CFG_WARN_LEVEL: warn_lvl_r   <= cfg_data;
          mcta_pkg::CFG_CRIT_LEVEL: crit_lvl_r   <= cfg_data;
          mcta_pkg::CFG_REC_LEVEL:  rec_lvl_r    <= cfg_data;
          mcta_pkg::CFG_MAX_CONSEC: max_consec_r <= cfg_data[mcta_pkg::CNT_W-1:0];
          default: begin
          end
        endcase
      end
      if (in_valid && in_ready) begin
        stg_valid_r <= 1'b1;
      end else if (advance) begin
        stg_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (advance) begin
        estop_r <= estop_nxt;
        if (sys_ok) begin
          status_r[idx]   <= new_st;
          consec_r[idx]   <= consec_upd;
          warn_tot_r[idx] <= warn_tot_upd;
          crit_tot_r[idx] <= crit_tot_upd;
          warn_ms_r[idx]  <= warn_ms_upd;
          crit_ms_r[idx]  <= crit_ms_upd;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r <= mcta_pkg::cmd_t'(in_cmd);
      sys_r <= in_sys_index;
      val_r <= in_sample_value;
      now_r <= in_now_ms;
    end
    if (advance) begin
      out_sys_r         <= sys_r;
      out_status_r      <= sys_ok ? new_st : mcta_pkg::ST_CRIT;
      out_changed_r     <= changed;
      out_became_crit_r <= changed && (new_st == mcta_pkg::ST_CRIT);
      out_overall_r     <= worst;
      out_consec_r      <= sys_ok ? consec_upd : '0;
      out_warn_tot_r    <= sys_ok ? warn_tot_upd : '0;
      out_crit_tot_r    <= sys_ok ? crit_tot_upd : '0;
      out_warn_ms_r     <= sys_ok ? warn_ms_upd : '0;
      out_crit_ms_r     <= sys_ok ? crit_ms_upd : '0;
    end
  end

  // The latch shown with a word is the value left by that word's command.
  logic estop_out_r;
  always_ff @(posedge clk) begin
    if (advance) begin
      estop_out_r <= estop_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_sys             = out_sys_r;
  assign out_sys_status      = out_status_r;
  assign out_status_changed  = out_changed_r;
  assign out_became_critical = out_became_crit_r;
  assign out_overall_status  = out_overall_r;
  assign out_estop_latched   = estop_out_r;
  assign out_consec_count    = out_consec_r;
  assign out_warn_total      = out_warn_tot_r;
  assign out_crit_total      = out_crit_tot_r;
  assign out_last_warn_ms    = out_warn_ms_r;
  assign out_last_crit_ms    = out_crit_ms_r;

endmodule

[rtl/mcta_checker.sv]
// Port-level checker for the threshold alarm core and its bind statement.
`include "multi_channel_threshold_alarm_core_macros.svh"

module mcta_checker #(
  parameter int NUM_SYSTEMS = mcta_pkg::NUM_SYSTEMS_DEF
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [mcta_pkg::SYS_W-1:0]       out_sys,
  input logic [1:0]                       out_sys_status,
  input logic                             out_status_changed,
  input logic                             out_became_critical,
  input logic [1:0]                       out_overall_status,
  input logic                             out_estop_latched,
  input logic [mcta_pkg::CNT_W-1:0]       out_consec_count,
  input logic [mcta_pkg::TOT_W-1:0]       out_warn_total,
  input logic [mcta_pkg::TOT_W-1:0]       out_crit_total,
  input logic [mcta_pkg::TIME_W-1:0]      out_last_warn_ms,
  input logic [mcta_pkg::TIME_W-1:0]      out_last_crit_ms
);

  localparam int CMP_W  = mcta_pkg::SYS_W + 2;
  localparam int WORD_W = mcta_pkg::SYS_W + 7 + mcta_pkg::CNT_W + 2 * mcta_pkg::TOT_W
                          + 2 * mcta_pkg::TIME_W;

  logic              sys_in_range;
  logic [WORD_W-1:0] out_word;
  logic              crit_word_ok;
  logic              overall_ok;

  assign sys_in_range = ({2'b00, out_sys} < CMP_W'(NUM_SYSTEMS));
  assign out_word     = {out_sys, out_sys_status, out_status_changed, out_became_critical,
                         out_overall_status, out_estop_latched, out_consec_count,
                         out_warn_total, out_crit_total, out_last_warn_ms, out_last_crit_ms};
  assign crit_word_ok = out_status_changed && (out_sys_status == mcta_pkg::ST_CRIT) &&
                        out_estop_latched && (out_overall_status == mcta_pkg::ST_CRIT);
  assign overall_ok   = (out_overall_status >= out_sys_status);

  // A stalled result word stays put.
  `MCTA_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_word))

  // A move into critical always trips the stop and shows as the worst status.
  `MCTA_ASSERT(a_crit_trips_stop, out_valid && out_became_critical |-> crit_word_ok)

  // The worst status never ranks below the status of a real subsystem.
  `MCTA_ASSERT(a_overall_covers, out_valid && sys_in_range |-> overall_ok)

  // Reset leaves no result word and an open command channel.
  `MCTA_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid && in_ready)

endmodule

bind multi_channel_threshold_alarm_core mcta_checker #(.NUM_SYSTEMS(NUM_SYSTEMS)) u_mcta_checker (.*);
